@@ src/pma_pkg.sv @@
// ----------------------------------------------------------------------------
// pma_pkg: shared types and constants for the palette match and allocate block
// Holds the command and result codes, the channel widths and the reset colors.
// ----------------------------------------------------------------------------
package pma_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int CH_W          = 6;
    localparam int DIST_W        = 14;
    localparam int THR_W         = 14;
    localparam logic [THR_W-1:0] THR_RESET = 14'd4;
    localparam logic [DIST_W:0]  FAR_DIST  = 15'd16383;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_WRITTEN = 3'd0,
        KIND_CLOSE   = 3'd1,
        KIND_ALLOC   = 3'd2,
        KIND_NEAREST = 3'd3,
        KIND_READ    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_color;

    // Reset contents of the first sixteen entries.
    function automatic t_color reset_color(input logic [3:0] i);
        t_color c;
        case (i)
            4'd0:    c = '{6'd63, 6'd63, 6'd63};
            4'd1:    c = '{6'd0,  6'd0,  6'd0};
            4'd2:    c = '{6'd63, 6'd0,  6'd0};
            4'd3:    c = '{6'd0,  6'd63, 6'd0};
            4'd4:    c = '{6'd0,  6'd0,  6'd63};
            4'd5:    c = '{6'd0,  6'd63, 6'd63};
            4'd6:    c = '{6'd63, 6'd63, 6'd0};
            4'd7:    c = '{6'd63, 6'd0,  6'd63};
            4'd8:    c = '{6'd31, 6'd31, 6'd31};
            4'd9:    c = '{6'd15, 6'd15, 6'd15};
            4'd10:   c = '{6'd63, 6'd31, 6'd31};
            4'd11:   c = '{6'd31, 6'd63, 6'd31};
            4'd12:   c = '{6'd31, 6'd31, 6'd63};
            4'd13:   c = '{6'd31, 6'd63, 6'd63};
            4'd14:   c = '{6'd63, 6'd63, 6'd31};
            default: c = '{6'd63, 6'd31, 6'd63};
        endcase
        return c;
    endfunction

endpackage

@@ src/palette_match_allocate.sv @@
// ----------------------------------------------------------------------------
// palette_match_allocate: palette store with nearest color match and allocate
// Keeps the palette in a ring of cells that rotates one entry per cycle while a command runs.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Beat contents
// command   in         i_start & !o_busy     i_cmd, i_index, i_red/green/blue_in
// result    out        o_done, one cycle     o_result_index, o_match_kind, colors
// config    in         i_cfg_we              i_cfg_data (match threshold)
//
// The palette lives in a ring of PALETTE_DEPTH cells. Every command rotates the
// ring one full turn, one entry per cycle, so entry k sits at the head cell while
// the scan position is k. Each command runs the turn itself, then a result
// state in which the last registered distance settles, then an idle state in
// which the next command is taken. The turn is what sets the rate. Reset
// loads the sixteen default colors and a used count of sixteen. The result
// strobe cannot be stalled.
// ----------------------------------------------------------------------------
module palette_match_allocate #(
    parameter int PALETTE_DEPTH = pma_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_data,
    output logic        o_done,
    output logic [7:0]  o_result_index,
    output logic [2:0]  o_match_kind,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);
    import pma_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(PALETTE_DEPTH - 1);
    localparam logic [AW-1:0] CNT_RESET = AW'((PALETTE_DEPTH < 16) ? PALETTE_DEPTH : 16);

    t_state          r_state, n_state;
    logic [THR_W-1:0] r_thr;
    logic [AW-1:0]   r_used, n_used;
    logic [AW-1:0]   r_pos, n_pos;      // entry at the head cell
    logic            r_cmp_v, n_cmp_v;  // distance register holds a live entry
    logic [AW-1:0]   r_cmp_idx, n_cmp_idx;
    t_cmd            r_cmd;
    logic [7:0]      r_idx;
    t_color          r_col;
    logic            r_hit, n_hit;
    logic [AW-1:0]   r_hit_idx, n_hit_idx;
    logic [DIST_W:0] r_best, n_best;
    logic [AW-1:0]   r_near, n_near;
    t_color          r_rd, n_rd;

    logic            shift;
    logic [AW-1:0]   wr_pos;
    logic            wr_en;
    t_color          cells [PALETTE_DEPTH];
    logic [DIST_W:0] scan_dist;

    // The ring: cell 0 is the head; shifting moves cell k+1 into cell k.
    genvar gi;
    generate
        for (gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_ring
            t_color rv;
            assign rv = (gi < 16) ? reset_color(4'(gi)) : '0;
            pma_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_reset_val(rv),
                .i_shift    (shift),
                .i_prev     ((gi == PALETTE_DEPTH - 1) ? cells[0]
                                                       : cells[(gi + 1) % PALETTE_DEPTH]),
                .i_load     (wr_en && gi == PALETTE_DEPTH - 1),
                .i_load_val (r_col),
                .o_color    (cells[gi])
            );
        end
    endgenerate

    pma_dist u_dist (
        .i_clk (i_clk),
        .i_a   (cells[0]),
        .i_b   (r_col),
        .o_dist(scan_dist)
    );

    // A write or an allocation replaces the head entry as it wraps to the tail.
    // The allocation slot comes up right after the last used entry, whose
    // distance settles in that same cycle, so the hit flag is taken from it.
    logic do_alloc;
    assign do_alloc = (r_cmd == CMD_MATCH) && !n_hit && (r_used < AW'(PALETTE_DEPTH));
    assign wr_pos = (r_cmd == CMD_WRITE) ? AW'(r_idx) : r_used;
    assign wr_en  = (r_state == ST_SCAN) && (r_pos == wr_pos) &&
                    ((r_cmd == CMD_WRITE && int'(r_idx) < PALETTE_DEPTH) || do_alloc);
    assign shift  = (r_state == ST_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_thr   <= THR_RESET;
            r_used  <= CNT_RESET;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_cmp_v <= n_cmp_v;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_best    <= n_best;
        r_near    <= n_near;
        r_rd      <= n_rd;
        if (r_state == ST_IDLE && i_start) begin
            r_cmd <= t_cmd'(i_cmd);
            r_idx <= i_index;
            r_col <= '{i_red_in[7:2], i_green_in[7:2], i_blue_in[7:2]};
        end
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_pos     = r_pos;
        n_cmp_v   = 1'b0;
        n_cmp_idx = r_pos;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_best    = r_best;
        n_near    = r_near;
        n_rd      = r_rd;
        o_done         = 1'b0;
        o_result_index = 8'd0;
        o_match_kind   = KIND_READ;
        o_red_out      = 8'd0;
        o_green_out    = 8'd0;
        o_blue_out     = 8'd0;

        // Settle the entry whose distance was registered last cycle.
        if (r_cmp_v && !r_hit) begin
            if (scan_dist < {1'b0, r_thr}) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end else if (scan_dist < r_best) begin
                n_best = scan_dist;
                n_near = r_cmp_idx;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_pos   = '0;
                    n_hit   = 1'b0;
                    n_best  = FAR_DIST;
                    n_near  = '0;
                    n_rd    = '0;
                end
            end
            ST_SCAN: begin
                n_cmp_v = (r_cmd == CMD_MATCH) && (r_pos != '0) && (r_pos < r_used);
                if ((r_cmd == CMD_READ || r_cmd == CMD_RSVD) &&
                    int'(r_idx) == int'(r_pos)) begin
                    n_rd = cells[0];
                end
                n_pos = r_pos + 1'b1;
                if (r_pos == LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // The last entry's distance settles in this cycle's comb logic.
                n_state = ST_IDLE;
                o_done  = 1'b1;
                case (r_cmd)
                    CMD_WRITE: begin
                        o_result_index = r_idx;
                        o_match_kind   = KIND_WRITTEN;
                        if (int'(r_idx) < PALETTE_DEPTH && AW'(r_idx) >= r_used) begin
                            n_used = AW'(r_idx) + 1'b1;
                        end
                    end
                    CMD_MATCH: begin
                        if (n_hit) begin
                            o_result_index = 8'(n_hit_idx);
                            o_match_kind   = KIND_CLOSE;
                        end else if (r_used < AW'(PALETTE_DEPTH)) begin
                            o_result_index = 8'(r_used);
                            o_match_kind   = KIND_ALLOC;
                            n_used         = r_used + 1'b1;
                        end else begin
                            o_result_index = 8'(n_near);
                            o_match_kind   = KIND_NEAREST;
                        end
                    end
                    default: begin
                        o_result_index = r_idx;
                        o_match_kind   = KIND_READ;
                        o_red_out      = {r_rd.r, 2'b00};
                        o_green_out    = {r_rd.g, 2'b00};
                        o_blue_out     = {r_rd.b, 2'b00};
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

@@ src/pma_cell.sv @@
// ----------------------------------------------------------------------------
// pma_cell: one palette entry in the rotating storage ring
// Holds one color and passes it to the next cell when the ring shifts.
// ----------------------------------------------------------------------------
module pma_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pma_pkg::t_color i_reset_val,
    input  logic            i_shift,
    input  pma_pkg::t_color i_prev,
    input  logic            i_load,
    input  pma_pkg::t_color i_load_val,
    output pma_pkg::t_color o_color
);
    import pma_pkg::*;

    t_color r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= i_reset_val;
        end else if (i_load) begin
            r_color <= i_load_val;
        end else if (i_shift) begin
            r_color <= i_prev;
        end
    end

    assign o_color = r_color;

endmodule

@@ src/pma_dist.sv @@
// ----------------------------------------------------------------------------
// pma_dist: squared RGB distance between two 6-bit colors, registered
// ----------------------------------------------------------------------------
module pma_dist (
    input  logic                      i_clk,
    input  pma_pkg::t_color           i_a,
    input  pma_pkg::t_color           i_b,
    output logic [pma_pkg::DIST_W:0]  o_dist
);
    import pma_pkg::*;

    logic [CH_W-1:0]  dr, dg, db;
    logic [DIST_W:0]  n_dist;
    logic [DIST_W:0]  r_dist;

    always_comb begin
        dr = (i_a.r > i_b.r) ? i_a.r - i_b.r : i_b.r - i_a.r;
        dg = (i_a.g > i_b.g) ? i_a.g - i_b.g : i_b.g - i_a.g;
        db = (i_a.b > i_b.b) ? i_a.b - i_b.b : i_b.b - i_a.b;
        n_dist = {3'd0, 12'(dr) * 12'(dr)} + {3'd0, 12'(dg) * 12'(dg)}
               + {3'd0, 12'(db) * 12'(db)};
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign o_dist = r_dist;

endmodule

@@ tb/pma_checker.sv @@
// ----------------------------------------------------------------------------
// pma_checker: result checker for the palette match and allocate block
// Watches command beats, result beats and threshold writes, keeps its own
// palette and used count, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pma_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_data,
    input  logic        i_done,
    input  logic [7:0]  i_result_index,
    input  logic [2:0]  i_match_kind,
    input  logic [7:0]  i_red_out,
    input  logic [7:0]  i_green_out,
    input  logic [7:0]  i_blue_out,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pma_pkg::*;

    localparam int NUM_ENTRIES = 256;
    localparam int FAR_SQUARE  = 63 * 63 * 63;

    typedef struct {
        logic [7:0] idx;
        t_kind      kind;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_expected;

    t_color      shadow_palette [NUM_ENTRIES];
    int          shadow_used;
    int          shadow_threshold;
    t_expected   expected_results [$];

    function automatic int square_gap(input logic [5:0] p, input logic [5:0] q);
        int d;
        d = int'(p) - int'(q);
        return d * d;
    endfunction

    // Applies one command beat to the shadow palette and returns its result.
    function automatic t_expected predict_palette(input t_cmd cmd, input logic [7:0] idx,
                                                  input t_color c);
        t_expected e;
        int        best;
        int        nearest;
        int        d;
        e = '{idx, KIND_WRITTEN, 8'd0, 8'd0, 8'd0};
        case (cmd)
            CMD_WRITE: begin
                shadow_palette[idx] = c;
                if (int'(idx) >= shadow_used) shadow_used = int'(idx) + 1;
                return e;
            end
            CMD_MATCH: begin
                best = FAR_SQUARE;
                nearest = 0;
                for (int i = 1; i < shadow_used && i < NUM_ENTRIES; i++) begin
                    d = square_gap(shadow_palette[i].r, c.r)
                      + square_gap(shadow_palette[i].g, c.g)
                      + square_gap(shadow_palette[i].b, c.b);
                    if (d < shadow_threshold) begin
                        e.idx = 8'(i);
                        e.kind = KIND_CLOSE;
                        return e;
                    end
                    if (d < best) begin
                        best = d;
                        nearest = i;
                    end
                end
                if (shadow_used < NUM_ENTRIES) begin
                    shadow_palette[shadow_used] = c;
                    e.idx = 8'(shadow_used);
                    e.kind = KIND_ALLOC;
                    shadow_used++;
                end else begin
                    e.idx = 8'(nearest);
                    e.kind = KIND_NEAREST;
                end
                return e;
            end
            default: begin
                // The unused command code reads like a plain read.
                e.kind = KIND_READ;
                e.r = {shadow_palette[idx].r, 2'b00};
                e.g = {shadow_palette[idx].g, 2'b00};
                e.b = {shadow_palette[idx].b, 2'b00};
                return e;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_expected e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++)
                shadow_palette[i] = (i < 16) ? reset_color(4'(i)) : '0;
            shadow_used = 16;
            shadow_threshold = int'(THR_RESET);
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) shadow_threshold = int'(i_cfg_data);
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (i_result_index !== e.idx || i_match_kind !== e.kind
                        || i_red_out !== e.r || i_green_out !== e.g
                        || i_blue_out !== e.b)
                        o_fail_count <= o_fail_count + 1;
                    if (i_result_index !== e.idx)
                        $error("result_index expected %0d got %0d", e.idx, i_result_index);
                    if (i_match_kind !== e.kind)
                        $error("match_kind expected %0d got %0d", e.kind, i_match_kind);
                    if (i_red_out !== e.r)
                        $error("red_out expected %0d got %0d", e.r, i_red_out);
                    if (i_green_out !== e.g)
                        $error("green_out expected %0d got %0d", e.g, i_green_out);
                    if (i_blue_out !== e.b)
                        $error("blue_out expected %0d got %0d", e.b, i_blue_out);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_palette(t_cmd'(i_cmd), i_index,
                    '{i_red_in[7:2], i_green_in[7:2], i_blue_in[7:2]}));
        end
        o_pending <= expected_results.size();
    end

endmodule

@@ tb/tb_palette_match_allocate.sv @@
// ----------------------------------------------------------------------------
// tb_palette_match_allocate: testbench for the palette match and allocate block
// Drives directed and random command beats and threshold settings; a separate
// checker predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_palette_match_allocate;
    timeunit 1ns;
    timeprecision 1ps;
    import pma_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_cmd = CMD_READ;
    logic [7:0]  i_index = '0;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        i_cfg_we = 1'b0;
    logic [13:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_done;
    logic [7:0]  o_result_index;
    logic [2:0]  o_match_kind;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    int          fail_count;
    int          pending_results;
    int          quiet_cycles = 0;
    int          sender_idle_pct;
    logic [23:0] sent_colors [$];

    always #5 i_clk = ~i_clk;

    palette_match_allocate uut (.*);

    pma_checker checker_inst (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cmd, .i_index,
        .i_red_in, .i_green_in, .i_blue_in, .i_cfg_we, .i_cfg_data,
        .i_done(o_done), .i_result_index(o_result_index), .i_match_kind(o_match_kind),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .o_fail_count(fail_count), .o_pending(pending_results)
    );

    // The watchdog counts cycles in which neither a command nor a result
    // beat moves. A whole palette turn is well under its limit.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_palette_match_allocate failed");
            $finish;
        end
    end

    // Presents one command beat and returns at the falling edge after the
    // edge that took it. The sender may idle first, at random.
    task automatic send_command(input t_cmd cmd, input logic [7:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd <= cmd;
        i_index <= idx;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        i_start <= 1'b1;
        sent_colors.push_back({r, g, b});
        if (sent_colors.size() > 32) void'(sent_colors.pop_front());
        // Busy only moves at rising edges, so its value here holds at the
        // next rising edge.
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Threshold writes happen only with the block idle and nothing pending.
    task automatic set_threshold(input logic [13:0] value);
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0 || o_busy) @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Picks a color: often near one already sent so that close matches and
    // nearest fallbacks happen, otherwise anywhere in the cube.
    task automatic pick_color(output logic [7:0] r, output logic [7:0] g,
                              output logic [7:0] b);
        logic [23:0] base;
        if (sent_colors.size() > 0 && $urandom_range(1)) begin
            base = sent_colors[$urandom_range(sent_colors.size() - 1)];
            r = base[23:16] ^ 8'($urandom_range(15));
            g = base[15:8] ^ 8'($urandom_range(15));
            b = base[7:0] ^ 8'($urandom_range(15));
        end else begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
    endtask

    task automatic random_phase(input int idle_pct);
        logic [7:0] r, g, b, idx;
        int         pick;
        sender_idle_pct = idle_pct;
        repeat (ITEMS_PER_PHASE) begin
            pick_color(r, g, b);
            pick = $urandom_range(99);
            idx = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(63));
            if (pick < 15) send_command(CMD_WRITE, idx, r, g, b);
            else if (pick < 70) send_command(CMD_MATCH, idx, r, g, b);
            else if (pick < 95) send_command(CMD_READ, idx, r, g, b);
            else send_command(CMD_RSVD, idx, r, g, b);
        end
    endtask

    initial begin
        sender_idle_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset threshold: default colors read back,
        // an exact match on a default color, an allocation, and the unused
        // command code acting as a read.
        send_command(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(CMD_READ, 8'd15, 8'd0, 8'd0, 8'd0);
        send_command(CMD_MATCH, 8'd0, 8'hFF, 8'h00, 8'h00);
        send_command(CMD_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_MATCH, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(CMD_MATCH, 8'd0, 8'h55, 8'hAA, 8'h33);
        send_command(CMD_READ, 8'd16, 8'd0, 8'd0, 8'd0);
        send_command(CMD_RSVD, 8'd16, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_READ, 8'd200, 8'd0, 8'd0, 8'd0);
        send_command(CMD_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_WRITE, 8'd20, 8'h03, 8'hFC, 8'h80);
        send_command(CMD_READ, 8'd20, 8'd0, 8'd0, 8'd0);
        send_command(CMD_MATCH, 8'd0, 8'h10, 8'h10, 8'h10);

        // A zero threshold never matches, so an exact color still allocates.
        set_threshold(14'd0);
        send_command(CMD_MATCH, 8'd0, 8'hFF, 8'h00, 8'h00);
        set_threshold(14'd11907);
        send_command(CMD_MATCH, 8'd0, 8'h7F, 8'h01, 8'hFE);

        // Writing the top entry fills the palette, so matches can no longer allocate;
        // both matches here fall within the threshold of a default gray entry.
        set_threshold(14'd4);
        send_command(CMD_WRITE, 8'd255, 8'h80, 8'h40, 8'h20);
        send_command(CMD_READ, 8'd255, 8'd0, 8'd0, 8'd0);
        send_command(CMD_MATCH, 8'd0, 8'h81, 8'h7F, 8'h7F);
        send_command(CMD_MATCH, 8'd0, 8'h40, 8'h40, 8'h40);

        // Random part: three idling profiles, each under its own threshold.
        set_threshold(14'($urandom_range(1, 200)));
        random_phase(31);
        set_threshold(14'($urandom_range(11907)));
        random_phase(53);
        set_threshold(14'd0);
        random_phase(0);

        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) $display("tb_palette_match_allocate passed");
        else $display("tb_palette_match_allocate failed");
        $finish;
    end

endmodule
